// ----- rtl/core/hto_pkg.sv -----
// Shared types, widths and codes of the open-addressing hash table.
`default_nettype none

package hto_pkg;

	// Default number of slots in the table memories.
	localparam int TABLE_SIZE_DEF = 2048;

	// Field widths.
	localparam int KIND_W     = 3;
	localparam int KEY_W      = 48;
	localparam int VAL_W      = 32;
	localparam int NUM_W      = 12;
	localparam int CFG_W      = 12;
	localparam int STATUS_W   = 2;
	localparam int SLOT_OUT_W = 11;
	localparam int MARK_W     = 2;

	// The sum of six squared bytes stays below 2^19.
	localparam int SUM_W = 19;

	// Reset value of the length register.
	localparam logic [CFG_W-1:0] LEN_RESET = 12'd2048;

	// Operation kinds.
	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOFREE   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DELETED  = 2'd3;

	// Slot marks.
	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [MARK_W-1:0] mark_t;

endpackage

`default_nettype wire

// ----- rtl/core/hash_table_open_addressing.sv -----
// Top level of the open-addressing hash table with a shared probe sequencer.
//
// Usage: an operation is sent on the input channel (in_valid, in_stall) with
// its kind, key, value and slot number. Exactly one result per operation
// leaves on the output channel (out_valid, out_stall). The user must write the
// slot count in use through the configuration channel (cfg_valid, cfg_ready)
// only while idle, which the block does not enforce; cfg_ready is always high.
// Steps: insert, search and delete square the key bytes one by one on one
// multiplier and reduce their sum in a bit-serial remainder unit, then
// probe slot by slot (memory read, then compare) and pass the result to the
// output register. Read slot reads its one slot; other kinds go straight
// to the output. A clear writes one slot mark per cycle over all slots.
// One operation is in work at a time; in_stall is high until it has finished.
// Reset: the length register returns to 2048 and a clearing pass empties
// every slot mark; in_stall stays high meanwhile.
// Stall: a result waits in the output register while out_stall is high. The
// next operation can be taken and computed meanwhile; its result waits in
// the sequencer until the output register is free.
`default_nettype none

module hash_table_open_addressing #(
	parameter int TABLE_SIZE = hto_pkg::TABLE_SIZE_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Configuration channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [hto_pkg::CFG_W-1:0]           table_length,
	// Input channel.
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [hto_pkg::KIND_W-1:0]          kind,
	input  wire logic [hto_pkg::KEY_W-1:0]           key,
	input  wire logic signed [hto_pkg::VAL_W-1:0]    value,
	input  wire logic [hto_pkg::NUM_W-1:0]           slot_number,
	// Output channel.
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [hto_pkg::STATUS_W-1:0]             status,
	output logic [hto_pkg::KEY_W-1:0]                out_key,
	output logic signed [hto_pkg::VAL_W-1:0]         out_value,
	output logic [hto_pkg::SLOT_OUT_W-1:0]           out_slot
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int LW = $clog2(TABLE_SIZE + 1);
	localparam int BW = $clog2(hto_pkg::SUM_W);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQR  = 4'd1;
	localparam logic [3:0] S_MOD  = 4'd2;
	localparam logic [3:0] S_PRD  = 4'd3;
	localparam logic [3:0] S_PCHK = 4'd4;
	localparam logic [3:0] S_RSL  = 4'd5;
	localparam logic [3:0] S_RCHK = 4'd6;
	localparam logic [3:0] S_CLR  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]                     state_q;
	logic [hto_pkg::CFG_W-1:0]      table_length_q;
	logic [hto_pkg::KIND_W-1:0]     kind_q;
	hto_pkg::key_t                  key_q;
	logic [hto_pkg::VAL_W-1:0]      val_q;
	logic [LW-1:0]                  len_q;
	logic [LW-1:0]                  idx_q;
	logic [2:0]                     byte_cnt_q;
	logic [BW-1:0]                  bit_q;
	logic [hto_pkg::SUM_W-1:0]      sum_q;
	logic [LW-1:0]                  rem_q;
	logic [AW-1:0]                  clr_q;
	logic                           clr_op_q;

	logic [hto_pkg::STATUS_W-1:0]   res_status_q;
	hto_pkg::key_t                  res_key_q;
	logic [hto_pkg::VAL_W-1:0]      res_val_q;
	logic [hto_pkg::SLOT_OUT_W-1:0] res_slot_q;

	logic                           out_valid_q;
	logic [hto_pkg::STATUS_W-1:0]   out_status_q;
	hto_pkg::key_t                  out_key_q;
	logic [hto_pkg::VAL_W-1:0]      out_val_q;
	logic [hto_pkg::SLOT_OUT_W-1:0] out_slot_q;

	// Table memories and their registered read data.
	hto_pkg::mark_t                 mark_mem [TABLE_SIZE];
	hto_pkg::key_t                  key_mem [TABLE_SIZE];
	logic [hto_pkg::VAL_W-1:0]      val_mem [TABLE_SIZE];
	hto_pkg::mark_t                 rd_mark_q;
	hto_pkg::key_t                  rd_key_q;
	logic [hto_pkg::VAL_W-1:0]      rd_val_q;

	logic                           in_xfer;
	logic                           out_free;
	logic [31:0]                    cfg_ext;
	logic [LW-1:0]                  len_use;
	logic [7:0]                     cur_byte;
	logic [15:0]                    byte_sq;
	logic [LW:0]                    rem_sh;
	logic [LW-1:0]                  rem_new;
	logic                           key_hit;
	logic                           num_ok;
	logic [hto_pkg::SLOT_OUT_W-1:0] idx_slot;
	logic                           mark_we;
	logic [AW-1:0]                  mark_waddr;
	hto_pkg::mark_t                 mark_wd;
	logic                           data_we;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Length in use: zero acts as one, values above the table size saturate.
	always_comb begin
		cfg_ext = {20'd0, table_length_q};
		if (cfg_ext == 32'd0) begin
			len_use = LW'(1);
		end else if (cfg_ext > 32'(TABLE_SIZE)) begin
			len_use = LW'(TABLE_SIZE);
		end else begin
			len_use = LW'(cfg_ext);
		end
	end

	// Shared squaring step: one key byte per cycle.
	assign cur_byte = key_q[{byte_cnt_q, 3'b000} +: 8];
	assign byte_sq  = cur_byte * cur_byte;

	// Shared remainder step: one dividend bit per cycle.
	always_comb begin
		rem_sh = {rem_q, sum_q[bit_q]};
		if (rem_sh >= {1'b0, len_q}) begin
			rem_new = LW'(rem_sh - {1'b0, len_q});
		end else begin
			rem_new = LW'(rem_sh);
		end
	end

	assign key_hit  = (rd_mark_q == hto_pkg::MARK_LIVE) && (rd_key_q == key_q);
	assign num_ok   = (slot_number != '0) && ({20'd0, slot_number} <= 32'(len_use));
	assign idx_slot = hto_pkg::SLOT_OUT_W'(32'(idx_q));

	// Memory write controls for the clearing pass, insert and delete.
	always_comb begin
		mark_we    = 1'b0;
		mark_waddr = idx_q[AW-1:0];
		mark_wd    = hto_pkg::MARK_LIVE;
		data_we    = 1'b0;
		if (state_q == S_CLR) begin
			mark_we    = 1'b1;
			mark_waddr = clr_q;
			mark_wd    = hto_pkg::MARK_EMPTY;
		end else if (state_q == S_PCHK) begin
			if (kind_q == hto_pkg::KIND_INSERT && rd_mark_q != hto_pkg::MARK_LIVE) begin
				mark_we = 1'b1;
				data_we = 1'b1;
			end else if (kind_q == hto_pkg::KIND_DELETE && key_hit) begin
				mark_we = 1'b1;
				mark_wd = hto_pkg::MARK_DELETED;
			end
		end
	end

	// Table memories: one write port, one registered read port at the probe index.
	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_waddr] <= mark_wd;
		end
		if (data_we) begin
			key_mem[idx_q[AW-1:0]] <= key_q;
			val_mem[idx_q[AW-1:0]] <= val_q;
		end
		rd_mark_q <= mark_mem[idx_q[AW-1:0]];
		rd_key_q  <= key_mem[idx_q[AW-1:0]];
		rd_val_q  <= val_mem[idx_q[AW-1:0]];
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= hto_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			table_length_q <= table_length;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			clr_op_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						kind_q       <= kind;
						key_q        <= key;
						val_q        <= value;
						len_q        <= len_use;
						byte_cnt_q   <= 3'd0;
						sum_q        <= '0;
						rem_q        <= '0;
						bit_q        <= BW'(hto_pkg::SUM_W - 1);
						res_status_q <= hto_pkg::ST_NOTFOUND;
						res_key_q    <= '0;
						res_val_q    <= '0;
						res_slot_q   <= '0;
						case (kind)
							hto_pkg::KIND_INSERT, hto_pkg::KIND_SEARCH,
							hto_pkg::KIND_DELETE: begin
								state_q <= S_SQR;
							end
							hto_pkg::KIND_READ: begin
								if (num_ok) begin
									idx_q   <= LW'(slot_number - 1'b1);
									state_q <= S_RSL;
								end else begin
									state_q <= S_OUT;
								end
							end
							hto_pkg::KIND_CLEAR: begin
								clr_q    <= '0;
								clr_op_q <= 1'b1;
								state_q  <= S_CLR;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				// Sum of squared key bytes.
				S_SQR: begin
					sum_q      <= sum_q + hto_pkg::SUM_W'(byte_sq);
					byte_cnt_q <= byte_cnt_q + 3'd1;
					if (byte_cnt_q == 3'd5) begin
						state_q <= S_MOD;
					end
				end
				// Home slot as the remainder of the sum by the length in use.
				S_MOD: begin
					rem_q <= rem_new;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						idx_q   <= rem_new;
						state_q <= S_PRD;
					end
				end
				// Bound check; the memory read of this slot is under way.
				S_PRD: begin
					if (idx_q >= len_q) begin
						if (kind_q == hto_pkg::KIND_INSERT) begin
							res_status_q <= hto_pkg::ST_NOFREE;
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_PCHK;
					end
				end
				// Examine the slot just read.
				S_PCHK: begin
					state_q <= S_PRD;
					idx_q   <= idx_q + 1'b1;
					case (kind_q)
						hto_pkg::KIND_INSERT: begin
							if (rd_mark_q != hto_pkg::MARK_LIVE) begin
								res_status_q <= hto_pkg::ST_DONE;
								res_slot_q   <= idx_slot;
								idx_q        <= idx_q;
								state_q      <= S_OUT;
							end
						end
						hto_pkg::KIND_SEARCH: begin
							if (rd_mark_q == hto_pkg::MARK_EMPTY) begin
								idx_q   <= idx_q;
								state_q <= S_OUT;
							end else if (key_hit) begin
								res_status_q <= hto_pkg::ST_DONE;
								res_val_q    <= rd_val_q;
								res_slot_q   <= idx_slot;
								idx_q        <= idx_q;
								state_q      <= S_OUT;
							end
						end
						default: begin
							if (key_hit) begin
								res_status_q <= hto_pkg::ST_DONE;
								res_slot_q   <= idx_slot;
								idx_q        <= idx_q;
								state_q      <= S_OUT;
							end
						end
					endcase
				end
				// Read slot: wait for the registered read.
				S_RSL: begin
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					res_slot_q <= idx_slot;
					if (rd_mark_q == hto_pkg::MARK_LIVE) begin
						res_status_q <= hto_pkg::ST_DONE;
						res_key_q    <= rd_key_q;
					end else if (rd_mark_q == hto_pkg::MARK_DELETED) begin
						res_status_q <= hto_pkg::ST_DELETED;
					end else begin
						res_status_q <= hto_pkg::ST_NOTFOUND;
					end
					state_q <= S_OUT;
				end
				// Clearing pass over every slot mark.
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(TABLE_SIZE - 1)) begin
						res_status_q <= hto_pkg::ST_DONE;
						clr_op_q     <= 1'b0;
						state_q      <= clr_op_q ? S_OUT : S_IDLE;
					end
				end
				// Hand the result to the output register once it is free.
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_val_q    <= res_val_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign out_key   = out_key_q;
	assign out_value = out_val_q;
	assign out_slot  = out_slot_q;

endmodule

`default_nettype wire
